// File: src/prr_pkg.sv
// Package for the polyphase rational resampler.
// Shared types, codes and constants. No dependencies.
package prr_pkg;

  // Default sizes for the top-level parameters
  localparam int DEF_MAX_PHASES = 32;
  localparam int DEF_MAX_TAPS   = 32;

  // Fixed field widths
  localparam int MAX_CHANNELS = 2;
  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 24;
  localparam int COEF_FRAC    = 22;
  localparam int MIN_TAPS     = 4;
  localparam int POS_W        = 7;
  localparam int UP_W         = 7;
  localparam int DOWN_W       = 6;
  localparam int TAPS_W       = 8;
  localparam int CHANS_W      = 2;
  localparam int CFG_W        = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CMD_W        = 2;
  localparam int ADDR_W       = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP    = 2'd0,
    REG_DOWN  = 2'd1,
    REG_TAPS  = 2'd2,
    REG_CHANS = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_LOOP,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [UP_W-1:0]    up;
    logic [DOWN_W-1:0]  down;
    logic [TAPS_W-1:0]  taps;
    logic [CHANS_W-1:0] chans;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              coef_wr;
    logic              clear;
    logic              hist_wr;
    logic              hist_ch;
    logic              rd_en;
    logic              acc_clr;
    logic              rd_ch;
    logic [POS_W-1:0]  rd_phase;
    logic [TAPS_W-1:0] rd_tap;
    logic              round;
    logic              out_load;
    logic              out_pass;
    logic              out_ch;
    logic              out_last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_sts_t;

endpackage

// File: src/prr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/prr_ctrl.sv
// Sequencer for the resampler: request intake, phase loop, tap loop, emission.
// Depends on prr_pkg.
module prr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  prr_pkg::cfg_t     cfg,
  input  prr_pkg::dp_sts_t  sts,
  output prr_pkg::dp_cmd_t  cmd
);
  import prr_pkg::*;

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               cc_r, cc_nxt;
  logic               ch_r, ch_nxt;
  logic [TAPS_W-1:0]  tap_r, tap_nxt;

  logic               accept;
  logic               idx;
  logic               last_ch;
  logic [POS_W-1:0]   pos_step;
  logic [CHANS_W-1:0] idx_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      cc_r    <= 1'b0;
      ch_r    <= 1'b0;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cc_r    <= cc_nxt;
      ch_r    <= ch_nxt;
      tap_r   <= tap_nxt;
    end
  end

  // Helpers
  assign accept   = in_valid && in_ready;
  assign idx      = ({1'b0, cc_r} >= cfg.chans) ? 1'b0 : cc_r;
  assign idx_ext  = CHANS_W'(idx) + CHANS_W'(1);
  assign last_ch  = ({1'b0, ch_r} == (cfg.chans - CHANS_W'(1)));
  assign pos_step = pos_r + POS_W'(cfg.down);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cc_nxt    = cc_r;
    ch_nxt    = ch_r;
    tap_nxt   = tap_r;
    in_ready  = 1'b0;
    cmd          = '0;
    cmd.hist_ch  = idx;
    cmd.rd_ch    = ch_r;
    cmd.rd_phase = pos_r;
    cmd.rd_tap   = tap_r;
    cmd.out_ch   = ch_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_COEF: cmd.coef_wr = 1'b1;
            CMD_CLEAR: begin
              cmd.clear = 1'b1;
              pos_nxt   = '0;
              cc_nxt    = 1'b0;
            end
            CMD_SAMPLE: begin
              cmd.hist_wr = 1'b1;
              if (idx_ext < cfg.chans) begin
                cc_nxt = 1'b1;
              end else begin
                cc_nxt = 1'b0;
                ch_nxt = 1'b0;
                if (cfg.up == UP_W'(cfg.down)) begin
                  state_nxt = ST_PASS;
                end else begin
                  state_nxt = ST_LOOP;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // Unfiltered: newest sample of each channel
      ST_PASS: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_pass = 1'b1;
          cmd.out_last = last_ch;
          if (last_ch) begin
            state_nxt = ST_IDLE;
          end else begin
            ch_nxt = 1'b1;
          end
        end
      end

      // Phase loop test
      ST_LOOP: begin
        if (UP_W'(pos_r) < cfg.up) begin
          ch_nxt    = 1'b0;
          tap_nxt   = '0;
          state_nxt = ST_MAC;
        end else begin
          pos_nxt   = pos_r - POS_W'(cfg.up);
          state_nxt = ST_IDLE;
        end
      end

      // One tap read per cycle
      ST_MAC: begin
        cmd.rd_en   = 1'b1;
        cmd.acc_clr = (tap_r == '0);
        if (tap_r == cfg.taps - TAPS_W'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          tap_nxt = tap_r + TAPS_W'(1);
        end
      end

      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.round = 1'b1;
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = last_ch && (UP_W'(pos_step) >= cfg.up);
          if (last_ch) begin
            pos_nxt   = pos_step;
            state_nxt = ST_LOOP;
          end else begin
            ch_nxt    = 1'b1;
            tap_nxt   = '0;
            state_nxt = ST_MAC;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: src/prr_dp.sv
// Datapath: coefficient and history RAMs, MAC pipeline, rounding, output register.
// Depends on prr_pkg and prr_ram.
module prr_dp #(
  parameter int MAX_PHASES = prr_pkg::DEF_MAX_PHASES,
  parameter int MAX_TAPS   = prr_pkg::DEF_MAX_TAPS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  prr_pkg::dp_cmd_t                         cmd,
  output prr_pkg::dp_sts_t                         sts,
  input  logic signed [prr_pkg::SAMPLE_BITS-1:0]   in_sample_in,
  input  logic [prr_pkg::ADDR_W-1:0]               in_coef_addr,
  input  logic signed [prr_pkg::COEF_BITS-1:0]     in_coef_value,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output logic signed [prr_pkg::SAMPLE_BITS-1:0]   out_sample_out,
  output logic                                     out_channel,
  output logic                                     out_last
);
  import prr_pkg::*;

  localparam int PH_W    = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int TP_W    = $clog2(MAX_TAPS);
  localparam int C_DEPTH = MAX_PHASES * MAX_TAPS;
  localparam int CA_W    = $clog2(C_DEPTH);
  localparam int H_DEPTH = 2 ** (TP_W + 1);
  localparam int HA_W    = TP_W + 1;
  localparam int PROD_W  = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W   = PROD_W + TP_W + 1;
  localparam logic [CA_W-1:0] TAPS_C = CA_W'(MAX_TAPS);
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

  // History ring state
  logic [TP_W-1:0]              wp_r [MAX_CHANNELS];
  logic [TP_W-1:0]              wp_nxt [MAX_CHANNELS];
  logic [H_DEPTH-1:0]           hv_r, hv_nxt;
  logic signed [SAMPLE_BITS-1:0] newest_r [MAX_CHANNELS];

  logic [TP_W-1:0]              wslot;
  logic [HA_W-1:0]              h_waddr, h_raddr;
  logic [CA_W-1:0]              c_waddr, c_raddr;
  logic                         c_we;
  logic [SAMPLE_BITS-1:0]       h_rdata;
  logic [COEF_BITS-1:0]         c_rdata;

  // MAC pipeline
  logic                         rv_r, pv_r, hvq_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic signed [SAMPLE_BITS-1:0] hgate;
  logic signed [ACC_W-1:0]      rnd, q;
  logic signed [SAMPLE_BITS-1:0] res_r;

  // Output register
  logic                         ov_r;
  logic signed [SAMPLE_BITS-1:0] osample_r;
  logic                         och_r, olast_r;

  // Addresses
  assign wslot   = wp_r[cmd.hist_ch] + TP_W'(1);
  assign h_waddr = {cmd.hist_ch, wslot};
  assign h_raddr = {cmd.rd_ch, wp_r[cmd.rd_ch] - TP_W'(cmd.rd_tap)};
  assign c_we    = cmd.coef_wr && (32'(in_coef_addr) < 32'(C_DEPTH));
  assign c_waddr = CA_W'(in_coef_addr);
  assign c_raddr = CA_W'(PH_W'(cmd.rd_phase)) * TAPS_C + CA_W'(TP_W'(cmd.rd_tap));

  prr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(H_DEPTH)) u_hist (
    .clk   (clk),
    .we    (cmd.hist_wr),
    .waddr (h_waddr),
    .wdata (in_sample_in),
    .re    (cmd.rd_en),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  prr_ram #(.WIDTH(COEF_BITS), .DEPTH(C_DEPTH)) u_coef (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (in_coef_value),
    .re    (cmd.rd_en),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // Ring pointers and valid bits; cleared slots read as silence
  always_comb begin
    hv_nxt = hv_r;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      wp_nxt[c] = wp_r[c];
    end
    if (cmd.clear) begin
      hv_nxt = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        wp_nxt[c] = '0;
      end
    end else if (cmd.hist_wr) begin
      hv_nxt[h_waddr]       = 1'b1;
      wp_nxt[cmd.hist_ch]   = wslot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        wp_r[c]     <= '0;
        newest_r[c] <= '0;
      end
    end else begin
      hv_r <= hv_nxt;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        wp_r[c] <= wp_nxt[c];
        if (cmd.clear) begin
          newest_r[c] <= '0;
        end else if (cmd.hist_wr && (cmd.hist_ch == 1'(c))) begin
          newest_r[c] <= in_sample_in;
        end
      end
    end
  end

  // MAC: read, multiply, accumulate
  assign hgate = hvq_r ? $signed(h_rdata) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      rv_r <= cmd.rd_en;
      pv_r <= rv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      hvq_r <= hv_r[h_raddr];
    end
    prod_r <= hgate * $signed(c_rdata);
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Round half up, scale, saturate
  assign rnd = acc_r + RND_BIAS;
  assign q   = rnd >>> COEF_FRAC;

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      if (q > SMAX) begin
        res_r <= SMAX[SAMPLE_BITS-1:0];
      end else if (q < SMIN) begin
        res_r <= SMIN[SAMPLE_BITS-1:0];
      end else begin
        res_r <= q[SAMPLE_BITS-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      osample_r <= cmd.out_pass ? newest_r[cmd.out_ch] : res_r;
      och_r     <= cmd.out_ch;
      olast_r   <= cmd.out_last;
    end
  end

  assign out_valid      = ov_r;
  assign out_sample_out = osample_r;
  assign out_channel    = och_r;
  assign out_last       = olast_r;

  assign sts.pipe_busy = rv_r || pv_r;
  assign sts.out_free  = !ov_r || out_ready;

endmodule

// File: src/polyphase_rational_resampler_core.sv
// Top level of the rational L/M polyphase FIR resampler.
// Depends on prr_pkg, prr_ctrl, prr_dp (and prr_ram through prr_dp).
//
//  Channel   Direction  Handshake              Payload
//  in_*      input      in_valid / in_ready    in_cmd, in_sample_in, in_coef_addr,
//                                              in_coef_value
//  out_*     output     out_valid / out_ready  out_sample_out, out_channel, out_last
//  cfg_*     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Coefficient writes, clears and samples that do not end a frame complete in the
// accepting cycle. A frame that ends runs one phase test per emitted phase plus a
// closing test, and per output the tap reads, a drain and round step and a load, with
// the single multiply-accumulate unit reading one tap per cycle. Pass-through frames
// emit the newest sample of each channel in turn. Reset is synchronous.
// A stalled output holds the sequencer before the next result is loaded.
module polyphase_rational_resampler_core #(
  parameter int MAX_PHASES = prr_pkg::DEF_MAX_PHASES,
  parameter int MAX_TAPS   = prr_pkg::DEF_MAX_TAPS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [prr_pkg::CMD_W-1:0]              in_cmd,
  input  logic signed [prr_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic [prr_pkg::ADDR_W-1:0]             in_coef_addr,
  input  logic signed [prr_pkg::COEF_BITS-1:0]   in_coef_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [prr_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic                                   out_channel,
  output logic                                   out_last,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [prr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [prr_pkg::CFG_W-1:0]              cfg_data
);
  import prr_pkg::*;

  logic [CFG_W-1:0]   up_r, down_r, taps_r;
  logic [CHANS_W-1:0] chans_r;
  cfg_t               cfg;
  dp_cmd_t            cmd;
  dp_sts_t            sts;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r    <= CFG_W'(1);
      down_r  <= CFG_W'(1);
      taps_r  <= CFG_W'(16);
      chans_r <= CHANS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_UP:    up_r    <= cfg_data;
        REG_DOWN:  down_r  <= cfg_data;
        REG_TAPS:  taps_r  <= cfg_data;
        REG_CHANS: chans_r <= cfg_data[CHANS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to legal ranges
  always_comb begin
    if (up_r == '0) begin
      cfg.up = UP_W'(1);
    end else if (32'(up_r) > MAX_PHASES) begin
      cfg.up = UP_W'(MAX_PHASES);
    end else begin
      cfg.up = UP_W'(up_r);
    end
    cfg.down = (down_r == '0) ? DOWN_W'(1) : down_r;
    if (32'(taps_r) < MIN_TAPS) begin
      cfg.taps = TAPS_W'(MIN_TAPS);
    end else if (32'(taps_r) > MAX_TAPS) begin
      cfg.taps = TAPS_W'(MAX_TAPS);
    end else begin
      cfg.taps = TAPS_W'(taps_r);
    end
    if (chans_r == '0) begin
      cfg.chans = CHANS_W'(1);
    end else if (32'(chans_r) > MAX_CHANNELS) begin
      cfg.chans = CHANS_W'(MAX_CHANNELS);
    end else begin
      cfg.chans = chans_r;
    end
  end

  prr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .cfg      (cfg),
    .sts      (sts),
    .cmd      (cmd)
  );

  prr_dp #(.MAX_PHASES(MAX_PHASES), .MAX_TAPS(MAX_TAPS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample_in   (in_sample_in),
    .in_coef_addr   (in_coef_addr),
    .in_coef_value  (in_coef_value),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_sample_out (out_sample_out),
    .out_channel    (out_channel),
    .out_last       (out_last)
  );

endmodule
